// ===== design/hse_pkg.sv =====
`default_nettype none
package hse_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int F_W = 32;
  localparam int P_W = 48;
  localparam int CFG_W = 47;
  localparam logic signed [63:0] LN2_Q32 = 64'sd2977044472;

  typedef enum logic [1:0] {
    MODEL_SOLID   = 2'd0,
    MODEL_PENALTY = 2'd1,
    MODEL_FLUID   = 2'd2,
    MODEL_BULK    = 2'd3
  } model_e;

  typedef enum logic [1:0] {
    REG_MODEL = 2'd0,
    REG_SHEAR = 2'd1,
    REG_LAME  = 2'd2,
    REG_BULK  = 2'd3
  } reg_e;

  // clamp a 128-bit value to signed 64 bits
  function automatic logic signed [63:0] sat128(input logic signed [127:0] a);
    logic signed [63:0] r;
    if (a[127:63] == {65{a[127]}}) begin
      r = a[63:0];
    end else begin
      r = a[127] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

  // round half up by s bits, then clamp to 64 bits
  function automatic logic signed [63:0] qrnd(input logic signed [127:0] a,
                                              input int unsigned s);
    logic signed [127:0] t;
    t = a + (128'sd1 <<< (s - 1));
    t = t >>> s;
    return sat128(t);
  endfunction

  function automatic logic signed [63:0] sat65(input logic signed [64:0] a);
    logic signed [63:0] r;
    if (a[64] == a[63]) begin
      r = a[63:0];
    end else begin
      r = a[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [63:0] adds(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] t;
    t = {a[63], a} + {b[63], b};
    return sat65(t);
  endfunction

  function automatic logic signed [63:0] subs(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] t;
    t = {a[63], a} - {b[63], b};
    return sat65(t);
  endfunction

  function automatic logic signed [63:0] half(input logic signed [63:0] a);
    logic [64:0] t;
    t = {a[63], a} + 65'd1;
    return t[64:1];
  endfunction

  function automatic logic signed [63:0] rnd64(input logic signed [63:0] a,
                                               input int unsigned s);
    logic signed [64:0] t;
    t = {a[63], a} + (65'sd1 <<< (s - 1));
    t = t >>> s;
    return sat65(t);
  endfunction

  function automatic logic [P_W-1:0] out48(input logic signed [63:0] a);
    logic [P_W-1:0] r;
    if (a[63:P_W-1] == {(65-P_W){a[63]}}) begin
      r = a[P_W-1:0];
    end else begin
      r = a[63] ? {1'b1, {(P_W-1){1'b0}}} : {1'b0, {(P_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/hse_mul.sv =====
`default_nettype none
// signed 64x64 multiplier, two stages: 32x32 partials, then sum and sign
module hse_mul (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [63:0]   a_i,
  input  logic signed [63:0]   b_i,
  output logic signed [127:0]  p_o
);

  logic [63:0]  ua, ub;
  logic [63:0]  pp_q [4];
  logic         neg_q;
  logic [127:0] sum;

  assign ua = a_i[63] ? 64'd0 - a_i : a_i;
  assign ub = b_i[63] ? 64'd0 - b_i : b_i;

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q[0] <= 64'(ua[31:0]) * 64'(ub[31:0]);
      pp_q[1] <= 64'(ua[31:0]) * 64'(ub[63:32]);
      pp_q[2] <= 64'(ua[63:32]) * 64'(ub[31:0]);
      pp_q[3] <= 64'(ua[63:32]) * 64'(ub[63:32]);
      neg_q   <= a_i[63] ^ b_i[63];
    end
  end

  assign sum = {64'd0, pp_q[0]} + {32'd0, pp_q[1], 32'd0} + {32'd0, pp_q[2], 32'd0}
             + {pp_q[3], 64'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= neg_q ? 128'd0 - sum : sum;
    end
  end

endmodule
`default_nettype wire

// ===== design/hyperelastic_stress_eval.sv =====
// Throughput: one item per cycle; the whole pipeline advances when the output
// register is empty or taken, so a stall on the output holds every stage.
// Depth is set by the 63-stage restoring divider for 2^62/J.
// Reset (rst_ni low, asynchronous) clears valid bits and configuration to 0.
`default_nettype none
module hyperelastic_stress_eval #(
  parameter int FRAC_BITS = hse_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,   // f_00, f_01, f_02, f_10 .. f_22, 32 bits each
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [479:0] m_axis_tdata,   // p_00 .. p_22, energy_density, 48 bits each
  output logic         m_axis_tuser,   // invalid
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int ST_J   = 5;
  localparam int ST_DV  = 6;
  localparam int DIV_N  = 63;
  localparam int LOG_N  = 32;
  localparam int ST_LN  = 42;
  localparam int ST_S   = 45;
  localparam int ST_E   = 49;
  localparam int ST_R   = 68;
  localparam int ST_G   = 71;
  localparam int ST_P   = 74;
  localparam int ST_OUT = 75;
  localparam logic signed [63:0] ONE   = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] THREE = 64'sd3 <<< FRAC_BITS;

  logic en;
  logic [ST_OUT:1] vld_q;

  // configuration registers
  hse_pkg::model_e         model_q;
  logic [hse_pkg::CFG_W-1:0] mu_q, lam_q, k_q;
  logic                    wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q <= hse_pkg::MODEL_SOLID;
      mu_q    <= '0;
      lam_q   <= '0;
      k_q     <= '0;
    end else if (wr) begin
      unique case (hse_pkg::reg_e'(paddr[4:3]))
        hse_pkg::REG_MODEL: model_q <= hse_pkg::model_e'(pwdata[1:0]);
        hse_pkg::REG_SHEAR: mu_q    <= pwdata[hse_pkg::CFG_W-1:0];
        hse_pkg::REG_LAME:  lam_q   <= pwdata[hse_pkg::CFG_W-1:0];
        hse_pkg::REG_BULK:  k_q     <= pwdata[hse_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (hse_pkg::reg_e'(paddr[4:3]))
      hse_pkg::REG_MODEL: prdata = {62'd0, model_q};
      hse_pkg::REG_SHEAR: prdata = {17'd0, mu_q};
      hse_pkg::REG_LAME:  prdata = {17'd0, lam_q};
      hse_pkg::REG_BULK:  prdata = {17'd0, k_q};
      default:            prdata = '0;
    endcase
  end

  logic signed [63:0] mu0, lam64, k64;
  assign mu0   = (model_q == hse_pkg::MODEL_SOLID) ? {17'd0, mu_q} : '0;
  assign lam64 = {17'd0, lam_q};
  assign k64   = {17'd0, k_q};

  // pipeline advance and valid chain
  assign en            = !vld_q[ST_OUT] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[ST_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ST_OUT-1:1], s_axis_tvalid};
    end
  end

  // input unpack and F delay line
  logic signed [31:0] fin [9];
  logic signed [31:0] f_q [1:ST_G][9];

  for (genvar i = 0; i < 9; i++) begin : g_unpack
    assign fin[i] = s_axis_tdata[32*i +: 32];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q[1] <= fin;
      for (int k = 2; k <= ST_G; k++) f_q[k] <= f_q[k-1];
    end
  end

  // row-0 cofactors and squares of F
  logic signed [63:0] ep1_q [3], ep2_q [3], c2_q [3];
  logic signed [63:0] sq_q [9], sr_q [9];
  logic signed [63:0] t_d;
  logic signed [63:0] t_q [3:ST_S];

  for (genvar b = 0; b < 3; b++) begin : g_cof0
    localparam int B1 = (b + 1) % 3;
    localparam int B2 = (b + 2) % 3;
    always_ff @(posedge clk_i) begin
      if (en) begin
        ep1_q[b] <= 64'(fin[3+B1]) * 64'(fin[6+B2]);
        ep2_q[b] <= 64'(fin[3+B2]) * 64'(fin[6+B1]);
        c2_q[b]  <= hse_pkg::qrnd(128'(ep1_q[b]) - 128'(ep2_q[b]), FRAC_BITS);
      end
    end
  end

  for (genvar i = 0; i < 9; i++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[i] <= 64'(fin[i]) * 64'(fin[i]);
        sr_q[i] <= hse_pkg::rnd64(sq_q[i], FRAC_BITS);
      end
    end
  end

  // trace of F^T F (no overflow possible)
  always_comb begin
    t_d = '0;
    for (int i = 0; i < 9; i++) t_d = t_d + sr_q[i];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q[3] <= t_d;
      for (int k = 4; k <= ST_S; k++) t_q[k] <= t_q[k-1];
    end
  end

  // determinant
  logic signed [127:0] jp [3];
  logic signed [63:0]  j_d, j5_q;
  logic                inv_q [ST_J:ST_P];

  for (genvar b = 0; b < 3; b++) begin : g_jmul
    hse_mul u_mul (.clk_i, .en_i(en), .a_i(64'(f_q[2][b])), .b_i(c2_q[b]), .p_o(jp[b]));
  end

  assign j_d = hse_pkg::qrnd(jp[0] + jp[1] + jp[2], FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en) begin
      j5_q       <= j_d;
      inv_q[ST_J] <= (j_d <= 0);
      for (int k = ST_J + 1; k <= ST_P; k++) inv_q[k] <= inv_q[k-1];
    end
  end

  // log2: leading-one position, normalize, then one squaring per stage
  logic [5:0]  m_d, m6_q, m7_q;
  logic [62:0] j6_q, jsh;
  logic [30:0] x7_q;
  logic [30:0] lx_q [LOG_N];
  logic [31:0] lf_q [LOG_N];
  logic [5:0]  lm_q [LOG_N];

  always_comb begin
    m_d = '0;
    for (int i = 0; i < 63; i++) begin
      if (j5_q[i]) m_d = 6'(i);
    end
  end

  assign jsh = j6_q << (6'd62 - m6_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m6_q <= m_d;
      j6_q <= j5_q[62:0];
      m7_q <= m6_q;
      x7_q <= jsh[62:32];
    end
  end

  for (genvar k = 0; k < LOG_N; k++) begin : g_log
    logic [30:0] xi;
    logic [31:0] fi;
    logic [5:0]  mi;
    logic [61:0] sqp;
    if (k == 0) begin : g_first
      assign xi = x7_q;
      assign fi = '0;
      assign mi = m7_q;
    end else begin : g_next
      assign xi = lx_q[k-1];
      assign fi = lf_q[k-1];
      assign mi = lm_q[k-1];
    end
    assign sqp = 62'(xi) * 62'(xi);
    always_ff @(posedge clk_i) begin
      if (en) begin
        lx_q[k] <= sqp[61] ? sqp[61:31] : sqp[60:30];
        lf_q[k] <= {fi[30:0], sqp[61]};
        lm_q[k] <= mi;
      end
    end
  end

  logic signed [7:0]   me;
  logic signed [63:0]  l2, ln42_q;
  logic signed [127:0] lnp;
  assign me = signed'({2'b00, lm_q[LOG_N-1]}) - 8'(FRAC_BITS);
  assign l2 = {{24{me[7]}}, me, lf_q[LOG_N-1]};

  hse_mul u_ln (.clk_i, .en_i(en), .a_i(l2), .b_i(hse_pkg::LN2_Q32), .p_o(lnp));

  always_ff @(posedge clk_i) begin
    if (en) ln42_q <= hse_pkg::rnd64(hse_pkg::qrnd(lnp, 32), 32 - FRAC_BITS);
  end

  // reciprocal 2^62 / J, one quotient bit per stage
  logic [62:0] dr_q [DIV_N], dq_q [DIV_N], dj_q [DIV_N];

  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    logic [62:0] rp, qp, jpv;
    logic [63:0] rem2, den;
    logic        ge;
    if (i == 0) begin : g_first
      assign rp  = '0;
      assign qp  = '0;
      assign jpv = j5_q[62:0];
    end else begin : g_next
      assign rp  = dr_q[i-1];
      assign qp  = dq_q[i-1];
      assign jpv = dj_q[i-1];
    end
    assign rem2 = {rp, (i == 0)};
    assign den  = {1'b0, jpv};
    assign ge   = rem2 >= den;
    always_ff @(posedge clk_i) begin
      if (en) begin
        dr_q[i] <= ge ? 63'(rem2 - den) : rem2[62:0];
        dq_q[i] <= {qp[61:0], ge};
        dj_q[i] <= jpv;
      end
    end
  end

  // J^2 - 1 and J - 1
  logic signed [127:0] jjp;
  logic signed [63:0]  q3_q, q1_q;

  hse_mul u_jj (.clk_i, .en_i(en), .a_i({1'b0, dj_q[ST_LN-3-ST_DV]}),
                .b_i({1'b0, dj_q[ST_LN-3-ST_DV]}), .p_o(jjp));

  always_ff @(posedge clk_i) begin
    if (en) begin
      q3_q <= hse_pkg::subs(hse_pkg::qrnd(jjp, FRAC_BITS), ONE);
      q1_q <= hse_pkg::subs({1'b0, dj_q[ST_LN-1-ST_DV]}, ONE);
    end
  end

  // model scalar s
  logic signed [63:0]  xs, s_d, sr;
  logic signed [127:0] sp;
  logic signed [63:0]  s_q [ST_S:ST_G];

  always_comb begin
    unique case (model_q)
      hse_pkg::MODEL_PENALTY: xs = q1_q;
      hse_pkg::MODEL_BULK:    xs = q3_q;
      default:                xs = ln42_q;
    endcase
  end

  hse_mul u_s (.clk_i, .en_i(en),
               .a_i((model_q == hse_pkg::MODEL_BULK) ? k64 : lam64), .b_i(xs), .p_o(sp));

  assign sr  = hse_pkg::qrnd(sp, FRAC_BITS);
  assign s_d = (model_q == hse_pkg::MODEL_BULK) ? hse_pkg::half(sr) : sr;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q[ST_S] <= s_d;
      for (int k = ST_S + 1; k <= ST_G; k++) s_q[k] <= s_q[k-1];
    end
  end

  // energy operands
  logic signed [63:0] yb_d;
  logic signed [63:0] yb_q [ST_LN+1:ST_S], lnd_q [ST_LN+1:ST_S];

  always_comb begin
    unique case (model_q)
      hse_pkg::MODEL_BULK:    yb_d = hse_pkg::subs(hse_pkg::half(q3_q), ln42_q);
      hse_pkg::MODEL_PENALTY: yb_d = q1_q;
      default:                yb_d = ln42_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      yb_q[ST_LN+1]  <= yb_d;
      lnd_q[ST_LN+1] <= ln42_q;
      for (int k = ST_LN + 2; k <= ST_S; k++) begin
        yb_q[k]  <= yb_q[k-1];
        lnd_q[k] <= lnd_q[k-1];
      end
    end
  end

  logic signed [127:0] xp, e1p, e2p;
  logic signed [63:0]  x48_q, e148_q, e248_q;
  logic signed [63:0]  e_q [ST_E:ST_P];

  hse_mul u_x (.clk_i, .en_i(en),
               .a_i((model_q == hse_pkg::MODEL_BULK) ? k64 : s_q[ST_S]),
               .b_i(yb_q[ST_S]), .p_o(xp));
  hse_mul u_e1 (.clk_i, .en_i(en), .a_i(mu0),
                .b_i(hse_pkg::subs(t_q[ST_S], THREE)), .p_o(e1p));
  hse_mul u_e2 (.clk_i, .en_i(en), .a_i(mu0), .b_i(lnd_q[ST_S]), .p_o(e2p));

  always_ff @(posedge clk_i) begin
    if (en) begin
      x48_q  <= hse_pkg::half(hse_pkg::qrnd(xp, FRAC_BITS));
      e148_q <= hse_pkg::half(hse_pkg::qrnd(e1p, FRAC_BITS));
      e248_q <= hse_pkg::qrnd(e2p, FRAC_BITS);
      e_q[ST_E] <= hse_pkg::adds(hse_pkg::subs(e148_q, e248_q), x48_q);
      for (int k = ST_E + 1; k <= ST_P; k++) e_q[k] <= e_q[k-1];
    end
  end

  // full cofactor matrix, recomputed to meet the reciprocal
  logic signed [63:0]  lp1_q [9], lp2_q [9];
  logic signed [63:0]  c_q [ST_R:ST_G][9];
  logic signed [127:0] gp [9], ap [9], bp [9];
  logic signed [63:0]  g71_q [9], a74_q [9], b74_q [9];

  for (genvar i = 0; i < 9; i++) begin : g_cof
    localparam int A1 = ((i / 3) + 1) % 3;
    localparam int A2 = ((i / 3) + 2) % 3;
    localparam int B1 = ((i % 3) + 1) % 3;
    localparam int B2 = ((i % 3) + 2) % 3;
    always_ff @(posedge clk_i) begin
      if (en) begin
        lp1_q[i] <= 64'(f_q[ST_R-2][3*A1+B1]) * 64'(f_q[ST_R-2][3*A2+B2]);
        lp2_q[i] <= 64'(f_q[ST_R-2][3*A1+B2]) * 64'(f_q[ST_R-2][3*A2+B1]);
        c_q[ST_R][i] <= hse_pkg::qrnd(128'(lp1_q[i]) - 128'(lp2_q[i]), FRAC_BITS);
        for (int k = ST_R + 1; k <= ST_G; k++) c_q[k][i] <= c_q[k-1][i];
      end
    end

    // inverse transpose entry
    hse_mul u_g (.clk_i, .en_i(en), .a_i(c_q[ST_R][i]), .b_i({1'b0, dq_q[DIV_N-1]}),
                 .p_o(gp[i]));
    always_ff @(posedge clk_i) begin
      if (en) g71_q[i] <= hse_pkg::qrnd(gp[i], 62 - FRAC_BITS);
    end

    // stress terms
    hse_mul u_a (.clk_i, .en_i(en), .a_i(mu0),
                 .b_i(hse_pkg::subs(64'(f_q[ST_G][i]), g71_q[i])), .p_o(ap[i]));
    hse_mul u_b (.clk_i, .en_i(en), .a_i(s_q[ST_G]),
                 .b_i((model_q == hse_pkg::MODEL_PENALTY) ? c_q[ST_G][i] : g71_q[i]),
                 .p_o(bp[i]));
    always_ff @(posedge clk_i) begin
      if (en) begin
        a74_q[i] <= hse_pkg::qrnd(ap[i], FRAC_BITS);
        b74_q[i] <= hse_pkg::qrnd(bp[i], FRAC_BITS);
      end
    end
  end

  // output register
  logic [hse_pkg::P_W-1:0] out_q [10];
  logic                    oinv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        out_q[i] <= inv_q[ST_P] ? '0
                  : hse_pkg::out48(hse_pkg::adds(a74_q[i], b74_q[i]));
      end
      out_q[9] <= inv_q[ST_P] ? '0 : hse_pkg::out48(e_q[ST_P]);
      oinv_q   <= inv_q[ST_P];
    end
  end

  for (genvar i = 0; i < 10; i++) begin : g_pack
    assign m_axis_tdata[48*i +: 48] = out_q[i];
  end
  assign m_axis_tuser = oinv_q;

endmodule
`default_nettype wire

// ===== design/hse_checker.sv =====
`default_nettype none
module hse_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [479:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         pready
);

  // input side opens exactly when the output register can move
  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not track output register");

  // a result flagged invalid carries all-zero stress and energy
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("invalid result with nonzero payload");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("config port not ready");

endmodule

bind hyperelastic_stress_eval hse_checker u_hse_checker (
  .clk_i,
  .rst_ni,
  .s_axis_tready,
  .m_axis_tvalid,
  .m_axis_tready,
  .m_axis_tdata,
  .m_axis_tuser,
  .pready
);
`default_nettype wire

// ===== verif/hyperelastic_stress_eval_tb.sv =====
`default_nettype none
module hyperelastic_stress_eval_tb;

  localparam int FB = 16;
  localparam int LIMIT = 2000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;   // f_00 .. f_22, 32 bits each, lowest first
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [479:0] m_axis_tdata;        // p_00 .. p_22, energy_density, 48 bits each
  logic         m_axis_tuser;        // invalid
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  hyperelastic_stress_eval uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  typedef struct {
    logic [479:0] data;
    logic         inv;
  } stress_t;

  // material settings mirrored from the register writes
  hse_pkg::model_e mdl = hse_pkg::MODEL_SOLID;
  logic [46:0] mu_q = '0, lam_q = '0, bulk_q = '0;

  stress_t     stress_q[$];
  int          errors = 0, n_sent = 0, n_checked = 0, n_invalid = 0;
  int          cycles = 0;
  bit          long_hold = 1'b0;
  int          burst_left = 0;

  typedef logic signed [127:0] w_t;
  typedef logic signed [63:0]  s_t;

  function automatic s_t mulq(s_t a, s_t b);
    w_t p;
    p = w_t'(a) * w_t'(b);
    p = (p + (w_t'(1) <<< (FB - 1))) >>> FB;
    if (p > w_t'(64'sh7FFF_FFFF_FFFF_FFFF)) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (p < -w_t'(64'sh7FFF_FFFF_FFFF_FFFF) - 1) return {1'b1, 63'b0};
    return p[63:0];
  endfunction

  function automatic s_t clamp64(w_t p);
    if (p > w_t'(64'sh7FFF_FFFF_FFFF_FFFF)) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (p < -w_t'(64'sh7FFF_FFFF_FFFF_FFFF) - 1) return {1'b1, 63'b0};
    return p[63:0];
  endfunction

  function automatic s_t sum_sat(s_t a, s_t b);
    return clamp64(w_t'(a) + w_t'(b));
  endfunction

  function automatic s_t diff_sat(s_t a, s_t b);
    return clamp64(w_t'(a) - w_t'(b));
  endfunction

  function automatic s_t halve(s_t a);
    return clamp64((w_t'(a) + 1) >>> 1);
  endfunction

  function automatic logic [47:0] clip48(s_t v);
    if (v > 64'sh7FFF_FFFF_FFFF) return 48'h7FFF_FFFF_FFFF;
    if (v < -64'sh8000_0000_0000) return 48'h8000_0000_0000;
    return v[47:0];
  endfunction

  // natural log of a positive Q16 value via mantissa squaring
  function automatic s_t log_q(s_t jv);
    logic [63:0]  u, x, frac;
    logic [127:0] sq;
    int           m;
    s_t           l2;
    u = jv;
    frac = '0;
    m = 0;
    while (m < 62 && (u >> (m + 1)) != 0) m++;
    x = (m >= 30) ? (u >> (m - 30)) : (u << (30 - m));
    for (int i = 0; i < 32; i++) begin
      sq = x * x;
      x = sq[93:30];
      frac = frac << 1;
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        frac[0] = 1'b1;
      end
    end
    l2 = s_t'(m - FB) * 64'sh1_0000_0000 + s_t'(frac);
    l2 = clamp64((w_t'(l2) * w_t'(64'sd2977044472) + (w_t'(1) <<< 31)) >>> 32);
    return clamp64((w_t'(l2) + (w_t'(1) <<< 15)) >>> 16);
  endfunction

  // stress and energy for one deformation gradient
  function automatic stress_t stress_of(logic [287:0] din);
    s_t f[3][3], c[3][3], g[3][3], p[3][3];
    s_t jd, ln, s, q, e, t, one;
    logic [63:0] r;
    w_t acc;
    stress_t res;
    one = s_t'(1) <<< FB;
    for (int k = 0; k < 9; k++) f[k/3][k%3] = s_t'($signed(din[32*k +: 32]));
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) begin
        acc = w_t'(f[(a+1)%3][(b+1)%3]) * f[(a+2)%3][(b+2)%3]
            - w_t'(f[(a+1)%3][(b+2)%3]) * f[(a+2)%3][(b+1)%3];
        c[a][b] = clamp64((acc + (w_t'(1) <<< (FB - 1))) >>> FB);
      end
    acc = w_t'(f[0][0]) * c[0][0] + w_t'(f[0][1]) * c[0][1] + w_t'(f[0][2]) * c[0][2];
    jd = clamp64((acc + (w_t'(1) <<< (FB - 1))) >>> FB);
    res.data = '0;
    res.inv = 1'b1;
    if (jd <= 0) return res;
    ln = log_q(jd);
    r = (64'd1 << 62) / jd;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        g[a][b] = clamp64((w_t'(c[a][b]) * w_t'({1'b0, r}) + (w_t'(1) <<< (61 - FB)))
                          >>> (62 - FB));
    case (mdl)
      hse_pkg::MODEL_SOLID: begin
        s = mulq(s_t'(lam_q), ln);
        for (int a = 0; a < 3; a++)
          for (int b = 0; b < 3; b++)
            p[a][b] = sum_sat(mulq(s_t'(mu_q), diff_sat(f[a][b], g[a][b])), mulq(s, g[a][b]));
        t = 0;
        for (int a = 0; a < 3; a++)
          for (int b = 0; b < 3; b++) t = sum_sat(t, mulq(f[a][b], f[a][b]));
        e = halve(mulq(s_t'(mu_q), diff_sat(t, 3 * one)));
        e = diff_sat(e, mulq(s_t'(mu_q), ln));
        e = sum_sat(e, halve(mulq(s, ln)));
      end
      hse_pkg::MODEL_PENALTY: begin
        q = diff_sat(jd, one);
        s = mulq(s_t'(lam_q), q);
        for (int a = 0; a < 3; a++)
          for (int b = 0; b < 3; b++) p[a][b] = mulq(s, c[a][b]);
        e = halve(mulq(s, q));
      end
      hse_pkg::MODEL_FLUID: begin
        s = mulq(s_t'(lam_q), ln);
        for (int a = 0; a < 3; a++)
          for (int b = 0; b < 3; b++) p[a][b] = mulq(s, g[a][b]);
        e = halve(mulq(s, ln));
      end
      default: begin
        q = diff_sat(mulq(jd, jd), one);
        s = halve(mulq(s_t'(bulk_q), q));
        for (int a = 0; a < 3; a++)
          for (int b = 0; b < 3; b++) p[a][b] = mulq(s, g[a][b]);
        e = halve(mulq(s_t'(bulk_q), diff_sat(halve(q), ln)));
      end
    endcase
    for (int k = 0; k < 9; k++) res.data[48*k +: 48] = clip48(p[k/3][k%3]);
    res.data[432 +: 48] = clip48(e);
    res.inv = 1'b0;
    return res;
  endfunction

  task automatic report(string what, int field, logic [47:0] got, logic [47:0] want);
    errors++;
    $display("mismatch %0s field %0d: got %h want %h", what, field, got, want);
  endtask

  // checker for every output transfer
  always @(posedge clk_i) begin
    stress_t want;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (stress_q.size() == 0) begin
        report("unexpected", -1, m_axis_tdata[47:0], '0);
      end else begin
        want = stress_q.pop_front();
        n_checked++;
        if (want.inv) n_invalid++;
        for (int k = 0; k < 10; k++)
          if (m_axis_tdata[48*k +: 48] !== want.data[48*k +: 48])
            report("data", k, m_axis_tdata[48*k +: 48], want.data[48*k +: 48]);
        if (m_axis_tuser !== want.inv)
          report("invalid", 10, 48'(m_axis_tuser), 48'(want.inv));
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    int hold;
    if (long_hold) begin
      m_axis_tready <= 1'b0;
      for (hold = 0; hold < 300; hold++) @(posedge clk_i);
      long_hold = 1'b0;
    end else if (cycles % 2000 < 500) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ((cycles / 7) % 3 != 0) && ($urandom_range(0, 3) != 0);
    end
  end

  // timeout guard
  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(hse_pkg::reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 3; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      hse_pkg::REG_MODEL: mdl = hse_pkg::model_e'(val[1:0]);
      hse_pkg::REG_SHEAR: mu_q = val[46:0];
      hse_pkg::REG_LAME:  lam_q = val[46:0];
      default:            bulk_q = val[46:0];
    endcase
  endtask

  task automatic set_material(hse_pkg::model_e m, logic [63:0] mu, logic [63:0] lam,
                              logic [63:0] k);
    write_reg(hse_pkg::REG_MODEL, 64'(m));
    write_reg(hse_pkg::REG_SHEAR, mu);
    write_reg(hse_pkg::REG_LAME, lam);
    write_reg(hse_pkg::REG_BULK, k);
  endtask

  // one input transfer, with bursts and gaps
  task automatic send_gradient(logic [287:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4) * ($urandom_range(0, 2) != 0);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    stress_q.push_back(stress_of(d));
    n_sent++;
    burst_left--;
  endtask

  task automatic drain;
    if (burst_left != 0 || s_axis_tvalid) s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (stress_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [31:0] near_one();
    return 32'($signed(32'h1_0000) + $signed(32'($urandom_range(0, 32768))) - 16384);
  endfunction

  function automatic logic [31:0] small_off();
    return 32'($signed(32'($urandom_range(0, 16384))) - 8192);
  endfunction

  // mostly near-identity gradients, some wide and raw ones
  function automatic logic [287:0] rand_gradient();
    logic [287:0] d;
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      if (kind == 0)      d[32*k +: 32] = $urandom;
      else if (kind == 1) d[32*k +: 32] = 32'($signed($urandom_range(0, 'h60000)) - 'h30000);
      else if (k % 4 == 0) d[32*k +: 32] = near_one();
      else                d[32*k +: 32] = small_off();
    end
    return d;
  endfunction

  function automatic logic [287:0] diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [287:0] d;
    d = '0;
    d[31:0] = a; d[128 +: 32] = b; d[256 +: 32] = c;
    return d;
  endfunction

  task automatic test_directed;
    logic [287:0] d;
    for (int m = 0; m < 4; m++) begin
      set_material(hse_pkg::model_e'(m), 64'h10_0000, 64'h20_0000, 64'h30_0000);
      send_gradient(diag(32'h1_0000, 32'h1_0000, 32'h1_0000));
      send_gradient(diag(32'h2_0000, 32'h8000, 32'h1_8000));
      send_gradient(diag(32'hFFFF_0000, 32'h1_0000, 32'h1_0000)); // negative det
      send_gradient('0);                                          // zero det
      d = diag(32'h1_0000, 32'h1_0000, 32'h1_0000);
      d[32 +: 32] = 32'h4000; d[224 +: 32] = 32'hFFFF_C000;
      send_gradient(d);
      drain();
    end
    // field extremes, huge determinant, tiny determinant
    set_material(hse_pkg::MODEL_SOLID, 64'h7FFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF,
                 64'h7FFF_FFFF_FFFF);
    send_gradient(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_gradient(diag(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_gradient({9{32'h8000_0000}});
    send_gradient({9{32'hFFFF_FFFF}});
    send_gradient(diag(32'h1, 32'h1_0000, 32'h1_0000));
    send_gradient(diag(32'h100, 32'h100, 32'h1_0000));
    drain();
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) send_gradient(rand_gradient());
    drain();
  endtask

  task automatic test_backpressure;
    long_hold = 1'b1;
    for (int k = 0; k < 150; k++) send_gradient(rand_gradient());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    for (int ph = 0; ph < 8; ph++) begin
      set_material(hse_pkg::model_e'(ph % 4),
                   ph == 4 ? 64'h7FFF_FFFF_FFFF : 64'($urandom_range(0, 'h40_0000)),
                   ph == 5 ? 64'h0 : 64'($urandom_range(0, 'h40_0000)),
                   ph == 7 ? 64'h7FFF_FFFF_FFFF : 64'($urandom_range(0, 'h40_0000)));
      test_random(200);
    end
    test_backpressure();
    $display("gradients sent %0d, results checked %0d, invalid %0d", n_sent, n_checked,
             n_invalid);
    $display("all four material models, extreme moduli and a long output hold-off run");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
